// ----- rtl/lzd_pkg.sv -----
// Shared types, codes and constants of the LZ77 block decoder.
`timescale 1ns / 1ps
`default_nettype none

package lzd_pkg;

    // Field widths fixed by the token and result formats
    localparam int CODE_W  = 24;
    localparam int POS_W   = 13;   // window positions and block_length
    localparam int LEN_W   = 6;    // copy length, at most 63
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Upper bound of addressable window: positions never exceed block_length
    localparam int POS_SPAN = 1 << POS_W;

    // Defaults
    localparam int BUFFER_DEPTH_DEF = 4096;
    localparam int MAX_COPY_DEF     = 63;
    localparam int CMD_FIFO_DEPTH   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_END  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_END = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_MATCH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN  = 2'd3;

    // Configuration reset values
    localparam logic [CODE_W-1:0] BLOCK_END_RST  = 24'hFFFFFE;
    localparam logic [CODE_W-1:0] STREAM_END_RST = 24'hFFFFFF;
    localparam logic [CODE_W-1:0] NO_MATCH_RST   = 24'hFFFFFD;
    localparam logic [POS_W-1:0]  BLOCK_LEN_RST  = 13'd4096;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BLOCK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STREAM = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd3;

    // Command opcodes from front to back
    localparam logic [1:0] OP_COPY   = 2'd0;
    localparam logic [1:0] OP_BLOCK  = 2'd1;
    localparam logic [1:0] OP_STREAM = 2'd2;
    localparam logic [1:0] OP_ERROR  = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0] match_start;
        logic [CODE_W-1:0] match_end;
        logic [BYTE_W-1:0] literal_byte;
        logic              literal_present;
    } t_token;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [1:0]        op;
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  len;
        logic              has_lit;
        logic [BYTE_W-1:0] lit;
    } t_cmd;

    typedef struct packed {
        logic             busy;
        logic [POS_W-1:0] wr_pos;
        logic [POS_W-1:0] fill;
    } t_back_status;

endpackage

`default_nettype wire

// ----- rtl/lz77_block_decoder.sv -----
// Top level of the LZ77 block decoder: configuration, classifier, queue, copy engine.
`timescale 1ns / 1ps
`default_nettype none

// LZ77 block decoder. Tokens enter through a queue-style port (push/full) and
// decoded results leave through another (empty/pop); each result carries a kind
// (data byte, block end, stream end or error), the byte and a last flag marking
// the final result of its token. The front classifies one token per cycle while
// the queue has room and parks it in a two-entry command queue, so up to two
// tokens are taken while the copy engine is still busy. The copy engine owns the
// single-port window memory: each token is issued from idle, each copied byte
// takes one registered read and then one write plus result, a literal one more
// write plus result, and a control or error token ends at its issue. The window
// needs no clearing pass after reset: a fill count tracks how far the window was
// ever written, and reads beyond it return zero. Once a stream-end token is seen,
// later tokens are taken and dropped until reset. Write the configuration only
// while the block is idle.
module lz77_block_decoder
    import lzd_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int MAX_COPY     = MAX_COPY_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output      logic                 full,
    input  wire t_token               i_token,
    output      logic                 empty,
    input  wire logic                 pop,
    output      t_result              o_result,
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CODE_W-1:0]    i_cfg_data
);

    // Window positions never exceed block_length, so the memory is clipped to that span
    localparam int MEM_DEPTH = (BUFFER_DEPTH < POS_SPAN) ? BUFFER_DEPTH : POS_SPAN;
    localparam logic [POS_W:0] DEPTH_LIM = (POS_W+1)'(MEM_DEPTH);

    logic [CODE_W-1:0] r_block_end_code;
    logic [CODE_W-1:0] r_stream_end_code;
    logic [CODE_W-1:0] r_no_match_code;
    logic [POS_W-1:0]  r_block_length;
    logic [POS_W:0]    cap_wide;
    logic [POS_W-1:0]  cap;

    logic         q_push;
    t_cmd         q_in;
    logic         q_full;
    logic         q_valid;
    t_cmd         q_out;
    logic         q_pop;
    t_back_status back_status;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_end_code  <= BLOCK_END_RST;
            r_stream_end_code <= STREAM_END_RST;
            r_no_match_code   <= NO_MATCH_RST;
            r_block_length    <= BLOCK_LEN_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BLOCK_END:  r_block_end_code  <= i_cfg_data;
                CFG_STREAM_END: r_stream_end_code <= i_cfg_data;
                CFG_NO_MATCH:   r_no_match_code   <= i_cfg_data;
                CFG_BLOCK_LEN:  r_block_length    <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Usable capacity: block_length limited to the window size
    assign cap_wide = ({1'b0, r_block_length} < DEPTH_LIM) ? {1'b0, r_block_length}
                                                           : DEPTH_LIM;
    assign cap      = cap_wide[POS_W-1:0];

    lzd_front #(
        .MAX_COPY (MAX_COPY)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_token           (i_token),
        .i_block_end_code  (r_block_end_code),
        .i_stream_end_code (r_stream_end_code),
        .i_no_match_code   (r_no_match_code),
        .i_cap             (cap),
        .i_q_full          (q_full),
        .o_q_push          (q_push),
        .o_q_cmd           (q_in)
    );

    lzd_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out)
    );

    lzd_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (cap),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out),
        .o_cmd_pop   (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .o_status    (back_status)
    );

    // The write position never runs ahead of the fill mark
    a_pos_below_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.wr_pos <= back_status.fill)
        else $error("write position ahead of fill count");

    // Control and error results close their transaction with a zero byte
    a_ctrl_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind != KIND_DATA) |-> (o_result.last && o_result.data_byte == '0))
        else $error("control result without last flag or with nonzero byte");

    // The engine only leaves idle by taking a command from the queue
    a_busy_from_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(back_status.busy) |-> $past(q_pop && q_valid))
        else $error("copy engine started without a command");

    // Queue is never pushed while full
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command queue overrun");

endmodule

`default_nettype wire

// ----- rtl/lzd_front.sv -----
// Token classifier: decodes control codes and checks copy bounds.
`timescale 1ns / 1ps
`default_nettype none

module lzd_front
    import lzd_pkg::*;
#(
    parameter int MAX_COPY = MAX_COPY_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output      logic              full,
    input  wire t_token            i_token,
    input  wire logic [CODE_W-1:0] i_block_end_code,
    input  wire logic [CODE_W-1:0] i_stream_end_code,
    input  wire logic [CODE_W-1:0] i_no_match_code,
    input  wire logic [POS_W-1:0]  i_cap,
    input  wire logic              i_q_full,
    output      logic              o_q_push,
    output      t_cmd              o_q_cmd
);

    logic              r_stream_done;
    logic              n_stream_done;
    logic              accept;
    logic              is_stream;
    logic              is_block;
    logic              has_copy;
    logic [CODE_W-1:0] diff;
    logic              copy_bad;

    assign full   = i_q_full;
    assign accept = push && !i_q_full;

    assign is_stream = (i_token.match_start == i_stream_end_code);
    assign is_block  = (i_token.match_start == i_block_end_code);
    assign has_copy  = (i_token.match_start != i_no_match_code)
                    && (i_token.match_end > i_token.match_start);
    assign diff      = i_token.match_end - i_token.match_start;
    assign copy_bad  = has_copy && ((diff > CODE_W'(MAX_COPY))
                    || (i_token.match_end > {{(CODE_W-POS_W){1'b0}}, i_cap}));

    always_comb begin
        n_stream_done   = r_stream_done;
        o_q_push        = 1'b0;
        o_q_cmd.op      = OP_COPY;
        o_q_cmd.start   = i_token.match_start[POS_W-1:0];
        o_q_cmd.len     = has_copy ? diff[LEN_W-1:0] : '0;
        o_q_cmd.has_lit = i_token.literal_present;
        o_q_cmd.lit     = i_token.literal_byte;
        // drop every token once the stream has ended
        if (accept && !r_stream_done) begin
            o_q_push = 1'b1;
            if (is_stream) begin
                o_q_cmd.op    = OP_STREAM;
                n_stream_done = 1'b1;
            end else if (is_block) begin
                o_q_cmd.op = OP_BLOCK;
            end else if (copy_bad) begin
                o_q_cmd.op = OP_ERROR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_done <= 1'b0;
        end else begin
            r_stream_done <= n_stream_done;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lzd_cmd_fifo.sv -----
// Short command queue between classifier and copy engine.
`timescale 1ns / 1ps
`default_nettype none

module lzd_cmd_fifo
    import lzd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output      logic o_full,
    input  wire logic i_pop,
    output      logic o_valid,
    output      t_cmd o_cmd
);

    localparam int DEPTH = CMD_FIFO_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lzd_back.sv -----
// Copy engine: window memory, write position and result register.
`timescale 1ns / 1ps
`default_nettype none

module lzd_back
    import lzd_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [POS_W-1:0] i_cap,
    input  wire logic             i_cmd_valid,
    input  wire t_cmd             i_cmd,
    output      logic             o_cmd_pop,
    output      logic             empty,
    input  wire logic             pop,
    output      t_result          o_result,
    output      t_back_status     o_status
);

    localparam int MEM_DEPTH = (BUFFER_DEPTH < POS_SPAN) ? BUFFER_DEPTH : POS_SPAN;
    localparam int AW        = $clog2(MEM_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_LIT   = 2'd3;

    logic [BYTE_W-1:0] r_mem [MEM_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    logic [1:0]        r_state,     n_state;
    logic [POS_W-1:0]  r_wr_pos,    n_wr_pos;
    logic [POS_W-1:0]  r_fill,      n_fill;
    logic [POS_W-1:0]  r_src,       n_src;
    logic [LEN_W-1:0]  r_left,      n_left;
    logic              r_has_lit,   n_has_lit;
    logic [BYTE_W-1:0] r_lit,       n_lit;
    logic              r_zero,      n_zero;
    logic              r_out_valid, n_out_valid;
    t_result           r_out,       n_out;

    logic              out_free;
    logic              rd_en;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_data;
    logic [POS_W:0]    need;

    assign out_free = !r_out_valid || pop;
    assign need     = {1'b0, r_wr_pos} + (POS_W+1)'(i_cmd.len) + (POS_W+1)'(i_cmd.has_lit);

    always_comb begin
        n_state     = r_state;
        n_wr_pos    = r_wr_pos;
        n_fill      = r_fill;
        n_src       = r_src;
        n_left      = r_left;
        n_has_lit   = r_has_lit;
        n_lit       = r_lit;
        n_zero      = r_zero;
        n_out_valid = r_out_valid && !pop;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_data     = r_lit;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop      = 1'b1;
                    n_out.data_byte = '0;
                    n_out.last      = 1'b1;
                    n_has_lit       = i_cmd.has_lit;
                    n_lit           = i_cmd.lit;
                    n_src           = i_cmd.start;
                    n_left          = i_cmd.len;
                    unique case (i_cmd.op)
                        OP_STREAM: begin
                            n_out_valid = 1'b1;
                            n_out.kind  = KIND_STREAM;
                        end
                        OP_BLOCK: begin
                            n_wr_pos    = '0;
                            n_out_valid = 1'b1;
                            n_out.kind  = KIND_BLOCK;
                        end
                        OP_ERROR: begin
                            n_out_valid = 1'b1;
                            n_out.kind  = KIND_ERROR;
                        end
                        default: begin
                            // overflow past the usable capacity turns the token into an error result
                            if (need > {1'b0, i_cap}) begin
                                n_out_valid = 1'b1;
                                n_out.kind  = KIND_ERROR;
                            end else if (i_cmd.len != '0) begin
                                n_state = ST_READ;
                            end else if (i_cmd.has_lit) begin
                                n_state = ST_LIT;
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                rd_en   = 1'b1;
                // never-written entries read as zero
                n_zero  = (r_src >= r_fill);
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free) begin
                    wr_en           = 1'b1;
                    wr_data         = r_zero ? '0 : r_rdata;
                    n_out_valid     = 1'b1;
                    n_out.kind      = KIND_DATA;
                    n_out.data_byte = wr_data;
                    n_out.last      = (r_left == LEN_W'(1)) && !r_has_lit;
                    n_wr_pos        = r_wr_pos + 1'b1;
                    if (r_wr_pos == r_fill) begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_src  = r_src + 1'b1;
                    n_left = r_left - 1'b1;
                    if (r_left == LEN_W'(1)) begin
                        n_state = r_has_lit ? ST_LIT : ST_IDLE;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_LIT: begin
                if (out_free) begin
                    wr_en           = 1'b1;
                    wr_data         = r_lit;
                    n_out_valid     = 1'b1;
                    n_out.kind      = KIND_DATA;
                    n_out.data_byte = r_lit;
                    n_out.last      = 1'b1;
                    n_wr_pos        = r_wr_pos + 1'b1;
                    if (r_wr_pos == r_fill) begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_pos[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_src[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_pos    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_pos    <= n_wr_pos;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src     <= n_src;
        r_left    <= n_left;
        r_has_lit <= n_has_lit;
        r_lit     <= n_lit;
        r_zero    <= n_zero;
        r_out     <= n_out;
    end

    assign empty           = !r_out_valid;
    assign o_result        = r_out;
    assign o_status.busy   = (r_state != ST_IDLE);
    assign o_status.wr_pos = r_wr_pos;
    assign o_status.fill   = r_fill;

endmodule

`default_nettype wire
